// ===== hdl/ppgt_pkg.sv =====
`timescale 1ns / 1ps

package ppgt_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int DC_W     = 16;
  localparam int AC_W     = 17;
  localparam int CODE_W   = 5;
  localparam int THR_W    = 16;

  // stream word widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  // window depth default
  localparam int DEPTH_DEFAULT = 64;

  // led current code limits
  localparam logic [CODE_W-1:0] CODE_MIN = CODE_W'(1);
  localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(20);

  // configuration register map
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THRESHOLD = 1'b1;

  localparam logic [THR_W-1:0] LOW_THRESHOLD_RESET  = 16'd29490;
  localparam logic [THR_W-1:0] HIGH_THRESHOLD_RESET = 16'd36044;

  // lane control from the sequencer
  typedef struct packed {
    logic load;     // capture the new sample
    logic update;   // write window, update sum, start divide
    logic divide;   // one divider step
    logic full;     // window entry at slot holds a real sample
  } ppgt_ctl_t;

endpackage

// ===== hdl/ppg_dc_ac_led_current_tracker.sv =====
`timescale 1ns / 1ps

// Red / infrared PPG splitter: each input word carries one red and one infrared
// sample; each output word gives the windowed mean (dc) of each channel over the
// last DEPTH samples (fewer until the window has filled), the sample minus that
// mean (ac), and the two LED current codes, which step once per window pass
// against low_threshold / high_threshold and stay within 1..20. Each input word
// passes accept, window read, update, 16 steps of the per-channel restoring
// divider and a result state, one word at a time. A new word is
// accepted while the previous result still waits in the output register. The
// window needs no clearing pass after reset: a fill count marks unwritten slots.

module ppg_dc_ac_led_current_tracker
  import ppgt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // red_sample [15:0], ir_sample [31:16]
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // red_dc [15:0], red_ac [32:16], ir_dc [48:33], ir_ac [65:49],
  // red_led_code [70:66], ir_led_code [75:71], zero [79:76]
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [THR_W-1:0]       cfg_wdata
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int STEP_W = $clog2(DC_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  state_t              state;
  logic [AW-1:0]       slot;
  logic [CW-1:0]       count;
  logic                full;
  logic                at_zero;
  logic [STEP_W-1:0]   steps;
  logic [THR_W-1:0]    low_threshold;
  logic [THR_W-1:0]    high_threshold;
  ppgt_ctl_t           ctl;
  logic                accept;
  logic                out_free;
  logic                step;

  logic [DC_W-1:0]          red_dc;
  logic [DC_W-1:0]          ir_dc;
  logic signed [AC_W-1:0]   red_ac;
  logic signed [AC_W-1:0]   ir_ac;
  logic [CODE_W-1:0]        red_code_next;
  logic [CODE_W-1:0]        ir_code_next;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = (state == ST_DONE) && out_free;

  assign ctl.load   = accept;
  assign ctl.update = (state == ST_UPDATE);
  assign ctl.divide = (state == ST_DIVIDE);
  assign ctl.full   = full;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= LOW_THRESHOLD_RESET;
      high_threshold <= HIGH_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_wdata;
        REG_HIGH_THRESHOLD: high_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer, ring position and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      slot    <= AW'(DEPTH - 3);
      count   <= '0;
      full    <= 1'b0;
      at_zero <= 1'b0;
      steps   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            full <= (count == CW'(DEPTH));
            if (count != CW'(DEPTH)) begin
              count <= count + 1'b1;
            end
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          at_zero <= (slot == '0);
          slot    <= (slot == AW'(DEPTH - 1)) ? '0 : slot + 1'b1;
          steps   <= '0;
          state   <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          steps <= steps + 1'b1;
          if (steps == STEP_W'(DC_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ppgt_lane #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_red_lane (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .slot      (slot),
    .count     (count),
    .sample_in (s_axis_tdata[SAMPLE_W-1:0]),
    .dc        (red_dc),
    .ac        (red_ac)
  );

  ppgt_lane #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ir_lane (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .slot      (slot),
    .count     (count),
    .sample_in (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .dc        (ir_dc),
    .ac        (ir_ac)
  );

  ppgt_track u_track (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .at_zero        (at_zero),
    .low_threshold  (low_threshold),
    .high_threshold (high_threshold),
    .red_dc         (red_dc),
    .ir_dc          (ir_dc),
    .red_code_next  (red_code_next),
    .ir_code_next   (ir_code_next)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {4'b0, ir_code_next, red_code_next, ir_ac, ir_dc, red_ac, red_dc};
    end
  end

endmodule

// ===== hdl/ppgt_lane.sv =====
`timescale 1ns / 1ps

module ppgt_lane
  import ppgt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ppgt_ctl_t                 ctl,
  input  logic [AW-1:0]             slot,
  input  logic [CW-1:0]             count,
  input  logic [SAMPLE_W-1:0]       sample_in,
  output logic [DC_W-1:0]           dc,
  output logic signed [AC_W-1:0]    ac
);

  localparam int SW = SAMPLE_W + AW;
  localparam int DW = CW + DC_W;

  logic [SAMPLE_W-1:0] window [DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] sample;
  logic [SW-1:0]       sum;
  logic [SW-1:0]       sum_next;
  logic [SW-1:0]       oldest;
  logic [SW-1:0]       rem;
  logic [DW-1:0]       div;
  logic [DC_W-1:0]     quo;
  logic                fits;

  // window memory, read every cycle, written once per word
  always_ff @(posedge clk) begin
    rd_data <= window[slot];
    if (ctl.update) begin
      window[slot] <= sample;
    end
  end

  // entries not yet written since reset read as zero
  assign oldest   = ctl.full ? SW'(rd_data) : '0;
  assign sum_next = sum + SW'(sample) - oldest;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.update) begin
      sum <= sum_next;
    end
  end

  // restoring divider, one quotient bit per step, msb first
  assign fits = DW'(rem) >= div;

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      rem <= sum_next;
      div <= DW'(count) << (DC_W - 1);
      quo <= '0;
    end else if (ctl.divide) begin
      if (fits) begin
        rem <= SW'(DW'(rem) - div);
      end
      div <= div >> 1;
      quo <= {quo[DC_W-2:0], fits};
    end
  end

  assign dc = quo;
  assign ac = signed'({1'b0, sample} - {1'b0, quo});

endmodule

// ===== hdl/ppgt_track.sv =====
`timescale 1ns / 1ps

module ppgt_track
  import ppgt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              at_zero,
  input  logic [THR_W-1:0]  low_threshold,
  input  logic [THR_W-1:0]  high_threshold,
  input  logic [DC_W-1:0]   red_dc,
  input  logic [DC_W-1:0]   ir_dc,
  output logic [CODE_W-1:0] red_code_next,
  output logic [CODE_W-1:0] ir_code_next
);

  logic [CODE_W-1:0] red_code;
  logic [CODE_W-1:0] ir_code;

  function automatic logic [CODE_W-1:0] adjust(
    input logic [CODE_W-1:0] code,
    input logic [DC_W-1:0]   level,
    input logic              enable,
    input logic [THR_W-1:0]  lo,
    input logic [THR_W-1:0]  hi
  );
    logic [CODE_W:0] moved;
    moved = {1'b0, code};
    if (enable) begin
      if (level < lo) begin
        moved = moved + 1'b1;
      end else if (level > hi) begin
        moved = moved - 1'b1;
      end
    end
    // lowering zero wraps to all ones, clamp low first
    if (moved[CODE_W] && moved != {1'b0, CODE_MAX} + 1'b1) begin
      return CODE_MIN;
    end else if (moved < {1'b0, CODE_MIN}) begin
      return CODE_MIN;
    end else if (moved > {1'b0, CODE_MAX}) begin
      return CODE_MAX;
    end else begin
      return moved[CODE_W-1:0];
    end
  endfunction

  // merge the lane means into the two led codes
  assign red_code_next = adjust(red_code, red_dc, at_zero, low_threshold, high_threshold);
  assign ir_code_next  = adjust(ir_code, ir_dc, at_zero, low_threshold, high_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_code <= '0;
      ir_code  <= '0;
    end else if (step) begin
      red_code <= red_code_next;
      ir_code  <= ir_code_next;
    end
  end

endmodule

// ===== bench/tb_ppg_dc_ac_led_current_tracker.sv =====
`timescale 1ns / 1ps

module tb_ppg_dc_ac_led_current_tracker;
  import ppgt_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam logic [SAMPLE_W-1:0] FULL = '1;

  // one input word: red in the low half
  typedef struct packed {
    logic [SAMPLE_W-1:0] ir;
    logic [SAMPLE_W-1:0] red;
  } sample_pair_t;

  // one output word, red_dc in the lowest bits
  typedef struct packed {
    logic [CODE_W-1:0] ir_code;
    logic [CODE_W-1:0] red_code;
    logic [AC_W-1:0]   ir_ac;
    logic [DC_W-1:0]   ir_dc;
    logic [AC_W-1:0]   red_ac;
    logic [DC_W-1:0]   red_dc;
  } tracker_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [THR_W-1:0]      cfg_wdata = '0;

  // mirrored tracker state
  logic [SAMPLE_W-1:0] red_ring [RING_DEPTH];
  logic [SAMPLE_W-1:0] ir_ring [RING_DEPTH];
  int unsigned red_acc = 0;
  int unsigned ir_acc = 0;
  int unsigned fill_cnt = 0;
  int unsigned ring_slot = RING_DEPTH - 3;
  int red_level = 0;
  int ir_level = 0;
  logic [THR_W-1:0] thr_low = LOW_THRESHOLD_RESET;
  logic [THR_W-1:0] thr_high = HIGH_THRESHOLD_RESET;

  sample_pair_t pending_pairs[$];
  tracker_out_t expected_outs[$];
  int unsigned pushed_cnt = 0;
  int unsigned offered_cnt = 0;
  int unsigned accepted_cnt = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int err_cnt = 0;
  int unsigned hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int unsigned cycle_cnt = 0;

  ppg_dc_ac_led_current_tracker #(
    .DEPTH(RING_DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // one hysteresis step of an led code
  function automatic int step_level(int level, int unsigned dc);
    if (dc < thr_low) return level + 1;
    if (dc > thr_high) return level - 1;
    return level;
  endfunction

  function automatic int clamp_level(int level);
    if (level < int'(CODE_MIN)) return int'(CODE_MIN);
    if (level > int'(CODE_MAX)) return int'(CODE_MAX);
    return level;
  endfunction

  // window update, dc / ac split and led tracking for one accepted word
  function automatic tracker_out_t split_dc_ac(sample_pair_t s);
    tracker_out_t r;
    int unsigned slot;
    int unsigned red_mean;
    int unsigned ir_mean;
    slot = ring_slot;
    red_acc = red_acc + s.red - red_ring[slot];
    red_ring[slot] = s.red;
    ir_acc = ir_acc + s.ir - ir_ring[slot];
    ir_ring[slot] = s.ir;
    if (fill_cnt < RING_DEPTH) fill_cnt = fill_cnt + 1;
    ring_slot = (slot + 1) % RING_DEPTH;
    red_mean = red_acc / fill_cnt;
    ir_mean = ir_acc / fill_cnt;
    // codes only move when the ring wraps through slot 0
    if (slot == 0) begin
      red_level = step_level(red_level, red_mean);
      ir_level = step_level(ir_level, ir_mean);
    end
    red_level = clamp_level(red_level);
    ir_level = clamp_level(ir_level);
    r.red_dc = DC_W'(red_mean);
    r.red_ac = AC_W'(int'(s.red) - int'(red_mean));
    r.ir_dc = DC_W'(ir_mean);
    r.ir_ac = AC_W'(int'(s.ir) - int'(ir_mean));
    r.red_code = CODE_W'(red_level);
    r.ir_code = CODE_W'(ir_level);
    return r;
  endfunction

  // random sample, now and then a full-scale extreme
  function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned lo, int unsigned hi);
    case ($urandom_range(19))
      0: return '0;
      1: return FULL;
      default: return SAMPLE_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // input word driver
  always @(negedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!s_valid || accepted_cnt == offered_cnt) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_data <= pending_pairs.pop_front();
        s_valid <= 1'b1;
        offered_cnt <= offered_cnt + 1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // output ready, random stalls plus the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off, armed once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // accepted words in, results checked against the predicted ones
  always @(posedge clk) begin : monitor
    tracker_out_t got;
    tracker_out_t want;
    if (!rst) begin
      if (s_valid && s_ready) begin
        expected_outs.push_back(split_dc_ac(sample_pair_t'(s_data)));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (m_valid && m_ready) begin
        got = tracker_out_t'(m_data[$bits(tracker_out_t)-1:0]);
        if (expected_outs.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected output word %h", m_data);
        end else begin
          want = expected_outs.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch (exp/got): red_dc %0d/%0d red_ac %0d/%0d ir_dc %0d/%0d",
                       want.red_dc, got.red_dc, $signed(want.red_ac), $signed(got.red_ac),
                       want.ir_dc, got.ir_dc);
              $display("  ir_ac %0d/%0d red_code %0d/%0d ir_code %0d/%0d",
                       $signed(want.ir_ac), $signed(got.ir_ac), want.red_code,
                       got.red_code, want.ir_code, got.ir_code);
            end
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[ppg_dc_ac_led_current_tracker] ERROR");
      $finish;
    end
  end

  task automatic queue_pair(logic [SAMPLE_W-1:0] red, logic [SAMPLE_W-1:0] ir);
    sample_pair_t p;
    p.red = red;
    p.ir = ir;
    pending_pairs.push_back(p);
    pushed_cnt++;
  endtask

  task automatic queue_random(int n, int unsigned lo, int unsigned hi);
    for (int k = 0; k < n; k++) queue_pair(pick_sample(lo, hi), pick_sample(lo, hi));
  endtask

  // all queued words taken and every result back
  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_cnt != pushed_cnt || expected_outs.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [THR_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    if (addr == REG_LOW_THRESHOLD) thr_low = value;
    else if (addr == REG_HIGH_THRESHOLD) thr_high = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // new thresholds and idling mix, only once the block is idle
  task automatic configure_phase(int tx, int rx, logic [THR_W-1:0] low,
                                 logic [THR_W-1:0] high);
    wait_drained();
    write_reg(REG_LOW_THRESHOLD, low);
    write_reg(REG_HIGH_THRESHOLD, high);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
  endtask

  initial begin : stimulus
    int unsigned base;
    for (int i = 0; i < RING_DEPTH; i++) begin
      red_ring[i] = '0;
      ir_ring[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, first wrap lowers a code already at 1
    configure_phase(0, 0, LOW_THRESHOLD_RESET, HIGH_THRESHOLD_RESET);
    queue_pair('0, '0);
    queue_pair(FULL, FULL);
    queue_pair(FULL, '0);
    queue_pair(FULL, FULL);
    queue_pair('0, FULL);
    queue_pair(16'h5555, 16'hAAAA);
    queue_pair(16'hAAAA, 16'h5555);
    queue_pair(16'h0001, 16'hFFFE);
    queue_pair(16'h8000, 16'h7FFF);
    queue_pair(16'h7FFF, 16'h8000);
    queue_pair(FULL, '0);
    queue_pair('0, FULL);
    queue_pair(FULL, FULL);

    // codes climb, no idling
    configure_phase(0, 0, FULL, FULL);
    queue_random(520, 0, 65535);

    // crossed thresholds, sender idle, with a full pause halfway
    configure_phase(49, 0, FULL, '0);
    queue_random(210, 0, 65535);
    wait_drained();
    queue_random(210, 0, 65535);

    // receiver stalls, long hold-off while words keep coming
    configure_phase(0, 49, FULL, 16'd40000);
    hold_go = 1'b1;
    queue_random(420, 0, 65535);

    // codes walk down, both sides idle
    configure_phase(18, 18, '0, '0);
    queue_random(350, 0, 65535);

    // back to reset thresholds, levels that straddle them
    configure_phase(18, 18, LOW_THRESHOLD_RESET, HIGH_THRESHOLD_RESET);
    for (int b = 0; b < 4; b++) begin
      base = $urandom_range(45000, 20000);
      queue_random(64, base - 3000, base + 3000);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ppg_dc_ac_led_current_tracker] OK");
    end else begin
      $display("[ppg_dc_ac_led_current_tracker] ERROR");
    end
    $finish;
  end

endmodule
